// ===== hdl/mlfd_pkg.sv =====
// shared types and constants for the marker/length frame deframer
package mlfd_pkg;

   // default store size in bytes
   localparam int BUF_BYTES_DEF = 1024;

   // frame markers
   localparam logic [7:0] MARK_S0 = 8'hA0;
   localparam logic [7:0] MARK_S1 = 8'hA2;
   localparam logic [7:0] MARK_E0 = 8'hB0;
   localparam logic [7:0] MARK_E1 = 8'hB3;

   // header plus trailer bytes around a payload
   localparam int FRAME_OVERHEAD = 8;

   // width used for lengths and byte counts
   localparam int LEN_W = 17;

   localparam logic [15:0] SKIP_MAX = 16'hFFFF;
   localparam logic [9:0] MAX_PAYLOAD_RST = 10'd1016;

   // item kinds on the request side
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // one queued request word
   typedef struct packed {
      logic       func;
      logic [7:0] stream_byte;
      logic [9:0] payload_index;
   } item_type;

   // engine status, counts zero-extended
   typedef struct packed {
      logic [LEN_W-1:0] fill;
      logic [LEN_W-1:0] scan;
   } eng_stat_type;

   // queue status
   typedef struct packed {
      logic       head_valid;
      logic [1:0] count;
   } que_stat_type;

endpackage

// ===== hdl/mlfd_front.sv =====
// request intake and two-entry queue in front of the frame engine
module mlfd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,
   input  logic [23:0]           req_tdata,
   input  logic                  pop,
   output mlfd_pkg::item_type    head,
   output mlfd_pkg::que_stat_type stat
);

   mlfd_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push_fire;
   logic       pop_fire;
   mlfd_pkg::item_type incoming;

   // classify the incoming word
   always_comb begin
      incoming.func          = req_tuser;
      incoming.stream_byte   = req_tdata[7:0];
      incoming.payload_index = req_tdata[17:8];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push_fire  = req_tvalid && req_tready;
   assign pop_fire   = pop && (count_ff != 2'd0);
   assign head       = entry_ff[rd_ptr_ff];
   assign stat.head_valid = (count_ff != 2'd0);
   assign stat.count      = count_ff;

   // queue storage
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= incoming;
      end
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_fire) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop_fire) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push_fire && !pop_fire) begin
            count_ff <= count_ff + 2'd1;
         end else if (!push_fire && pop_fire) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

// ===== hdl/mlfd_engine.sv =====
// byte store, frame scan sequencer and result register
module mlfd_engine #(
   parameter int BUF_BYTES = mlfd_pkg::BUF_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [9:0]              max_payload,
   input  mlfd_pkg::item_type      head,
   input  logic                    head_valid,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_found,
   output logic [9:0]              rsp_length,
   output logic [15:0]             rsp_checksum,
   output logic [15:0]             rsp_skipped,
   output logic [7:0]              rsp_read_byte,
   output mlfd_pkg::eng_stat_type  stat
);

   localparam int AW = $clog2(BUF_BYTES);
   localparam int CW = $clog2(BUF_BYTES + 1);
   localparam int LW = mlfd_pkg::LEN_W;
   localparam logic [LW-1:0] OVH = LW'(mlfd_pkg::FRAME_OVERHEAD);
   localparam logic [LW-1:0] ROOM = LW'(BUF_BYTES - mlfd_pkg::FRAME_OVERHEAD);
   localparam logic [AW:0] BUF_P = (AW+1)'(BUF_BYTES);

   typedef enum logic [4:0] {
      S_IDLE, S_COMPACT, S_WRITE, S_CHECK, S_HUNT_A, S_HUNT_B, S_HUNT_C,
      S_HDR, S_LEN_A, S_LEN_B, S_TAIL_A, S_TAIL_B, S_TAIL_C, S_TAIL_D,
      S_TAIL_E, S_FOUND, S_RD_CAP, S_RD_OUT
   } state_type;

   state_type     state_ff;
   logic [7:0]    mem [BUF_BYTES];
   logic [7:0]    rdata_ff;
   logic [AW-1:0] base_ff;
   logic [CW-1:0] fill_ff;
   logic [CW-1:0] scan_ff;
   logic [15:0]   skip_ff;
   logic          held_valid_ff;
   logic [AW-1:0] held_start_ff;
   logic [9:0]    held_len_ff;
   logic [7:0]    byte_ff;
   logic          rd_ok_ff;
   logic [7:0]    b0_ff;
   logic [7:0]    hi_ff;
   logic [LW-1:0] len_ff;
   logic [15:0]   csum_ff;
   logic          out_valid_ff;
   logic          out_found_ff;
   logic [9:0]    out_len_ff;
   logic [15:0]   out_csum_ff;
   logic [15:0]   out_skip_ff;
   logic [7:0]    out_byte_ff;

   logic [LW-1:0] limit;
   logic [LW-1:0] avail;
   logic [LW-1:0] scan_x;
   logic [LW-1:0] off;
   logic [LW-1:0] lg_full;
   logic [AW-1:0] lg;
   logic [AW:0]   rsum;
   logic [AW-1:0] raddr;
   logic [AW:0]   wsum;
   logic [AW-1:0] waddr;
   logic          we;
   logic          slot_free;
   logic          out_set;
   logic [LW-1:0] len_now;
   logic [LW-1:0] next_scan;

   // effective payload limit
   assign limit = (LW'(max_payload) > ROOM) ? ROOM : LW'(max_payload);
   assign scan_x = LW'(scan_ff);
   assign avail  = LW'(fill_ff) - scan_x;
   assign slot_free = !out_valid_ff || rsp_ready;
   assign out_set = slot_free && (state_ff == S_FOUND || state_ff == S_RD_OUT);
   assign len_now = {{(LW-16){1'b0}}, hi_ff, rdata_ff};
   assign next_scan = scan_x + len_ff + OVH;

   // offset from the scan position per read step
   always_comb begin
      case (state_ff)
         S_HUNT_B: off = LW'(1);
         S_HDR:    off = LW'(2);
         S_LEN_A:  off = LW'(3);
         S_TAIL_A: off = len_ff + LW'(4);
         S_TAIL_B: off = len_ff + LW'(5);
         S_TAIL_C: off = len_ff + LW'(6);
         S_TAIL_D: off = len_ff + LW'(7);
         default:  off = '0;
      endcase
   end

   // logical read position to ring address
   always_comb begin
      if (state_ff == S_IDLE) begin
         lg_full = LW'(held_start_ff) + LW'(4) + LW'(head.payload_index);
      end else begin
         lg_full = scan_x + off;
      end
      lg   = lg_full[AW-1:0];
      rsum = {1'b0, base_ff} + {1'b0, lg};
      if (rsum >= BUF_P) begin
         rsum = rsum - BUF_P;
      end
      raddr = rsum[AW-1:0];
   end

   // write position to ring address
   always_comb begin
      wsum = {1'b0, base_ff} + (AW+1)'(fill_ff);
      if (wsum >= BUF_P) begin
         wsum = wsum - BUF_P;
      end
      waddr = wsum[AW-1:0];
   end

   assign we  = (state_ff == S_WRITE);
   assign pop = (state_ff == S_IDLE) && head_valid;

   // byte store
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= byte_ff;
      end
      rdata_ff <= mem[raddr];
   end

   // scan sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         base_ff       <= '0;
         fill_ff       <= '0;
         scan_ff       <= '0;
         skip_ff       <= '0;
         held_valid_ff <= 1'b0;
         held_start_ff <= '0;
         held_len_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_set || (out_valid_ff && !rsp_ready);
         case (state_ff)
            S_IDLE: begin
               if (head_valid) begin
                  byte_ff  <= head.stream_byte;
                  rd_ok_ff <= held_valid_ff && (head.payload_index < held_len_ff);
                  if (head.func == mlfd_pkg::FUNC_READ) begin
                     state_ff <= S_RD_CAP;
                  end else begin
                     held_valid_ff <= 1'b0;
                     state_ff <= (fill_ff == CW'(BUF_BYTES)) ? S_COMPACT : S_WRITE;
                  end
               end
            end
            S_COMPACT: begin
               base_ff  <= raddr;
               fill_ff  <= (scan_ff == '0) ? '0 : fill_ff - scan_ff;
               scan_ff  <= '0;
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               fill_ff  <= fill_ff + CW'(1);
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               state_ff <= (avail < OVH) ? S_IDLE : S_HUNT_A;
            end
            S_HUNT_A: begin
               state_ff <= (scan_ff + CW'(1) < fill_ff) ? S_HUNT_B : S_HDR;
            end
            S_HUNT_B: begin
               b0_ff    <= rdata_ff;
               state_ff <= S_HUNT_C;
            end
            S_HUNT_C: begin
               if (b0_ff == mlfd_pkg::MARK_S0 && rdata_ff == mlfd_pkg::MARK_S1) begin
                  state_ff <= S_HDR;
               end else begin
                  if (skip_ff != mlfd_pkg::SKIP_MAX) begin
                     skip_ff <= skip_ff + 16'd1;
                  end
                  scan_ff  <= scan_ff + CW'(1);
                  state_ff <= S_HUNT_A;
               end
            end
            S_HDR: begin
               state_ff <= (avail < OVH) ? S_IDLE : S_LEN_A;
            end
            S_LEN_A: begin
               hi_ff    <= rdata_ff;
               state_ff <= S_LEN_B;
            end
            S_LEN_B: begin
               len_ff <= len_now;
               if (len_now > limit) begin
                  scan_ff  <= scan_ff + CW'(1);
                  state_ff <= S_CHECK;
               end else if (avail < len_now + OVH) begin
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_TAIL_A;
               end
            end
            S_TAIL_A: begin
               state_ff <= S_TAIL_B;
            end
            S_TAIL_B: begin
               hi_ff    <= rdata_ff;
               state_ff <= S_TAIL_C;
            end
            S_TAIL_C: begin
               csum_ff  <= {hi_ff, rdata_ff};
               state_ff <= S_TAIL_D;
            end
            S_TAIL_D: begin
               b0_ff    <= rdata_ff;
               state_ff <= S_TAIL_E;
            end
            S_TAIL_E: begin
               if (b0_ff == mlfd_pkg::MARK_E0 && rdata_ff == mlfd_pkg::MARK_E1) begin
                  state_ff <= S_FOUND;
               end else begin
                  scan_ff  <= scan_ff + CW'(1);
                  state_ff <= S_CHECK;
               end
            end
            S_FOUND: begin
               if (slot_free) begin
                  out_found_ff  <= 1'b1;
                  out_len_ff    <= len_ff[9:0];
                  out_csum_ff   <= csum_ff;
                  out_skip_ff   <= skip_ff;
                  out_byte_ff   <= 8'd0;
                  held_valid_ff <= 1'b1;
                  held_start_ff <= scan_ff[AW-1:0];
                  held_len_ff   <= len_ff[9:0];
                  skip_ff       <= '0;
                  if (next_scan == LW'(fill_ff)) begin
                     scan_ff <= '0;
                     fill_ff <= '0;
                  end else begin
                     scan_ff <= next_scan[CW-1:0];
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_RD_CAP: begin
               byte_ff  <= rd_ok_ff ? rdata_ff : 8'd0;
               state_ff <= S_RD_OUT;
            end
            S_RD_OUT: begin
               if (slot_free) begin
                  out_found_ff <= 1'b0;
                  out_len_ff   <= '0;
                  out_csum_ff  <= '0;
                  out_skip_ff  <= '0;
                  out_byte_ff  <= byte_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_found     = out_found_ff;
   assign rsp_length    = out_len_ff;
   assign rsp_checksum  = out_csum_ff;
   assign rsp_skipped   = out_skip_ff;
   assign rsp_read_byte = out_byte_ff;
   assign stat.fill     = LW'(fill_ff);
   assign stat.scan     = scan_x;

endmodule

// ===== hdl/marker_length_frame_deframer_core.sv =====
// top level of the marker/length frame deframer
// Usage: words enter on req_ (tuser 0 pushes a stream byte, 1 reads one payload
// byte of the frame found by the last push). A push yields a word on rsp_ only
// when it completes a frame, with length, checksum and skip count; a read
// always yields one word with the payload byte (0 when out of range or when
// no frame is held). csr_wr_en writes the payload length limit at any idle
// time. A two-word queue takes requests while the scan engine is busy, and
// the result register lets the engine go on while rsp_tready is low; a stall
// on rsp_ holds the word and the engine waits only when it has a next result.
// A read captures the held payload byte and then outputs it. A push moves the
// ring base when the store is full, writes the byte and, when at least 8 bytes
// are pending, hunts the start marker byte by byte, reads the length header and
// then the trailer. The single store read port sets the pace.
// Reset (synchronous, high) empties the store, clears the skip count and
// held frame, and sets the limit to 1016; no clearing pass is needed.
module marker_length_frame_deframer_core #(
   parameter int BUF_BYTES = mlfd_pkg::BUF_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // func
   input  logic [23:0] req_tdata,   // stream_byte, payload_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,   // frame_found
   output logic [55:0] rsp_tdata,   // frame_length, frame_checksum, skipped_count, read_byte
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data
);

   logic [9:0] max_payload_ff;
   mlfd_pkg::item_type     head;
   mlfd_pkg::que_stat_type q_stat;
   mlfd_pkg::eng_stat_type e_stat;
   logic        pop;
   logic [9:0]  length;
   logic [15:0] checksum;
   logic [15:0] skipped;
   logic [7:0]  read_byte;

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= mlfd_pkg::MAX_PAYLOAD_RST;
      end else if (csr_wr_en) begin
         max_payload_ff <= csr_wr_data;
      end
   end

   mlfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .pop        (pop),
      .head       (head),
      .stat       (q_stat)
   );

   mlfd_engine #(
      .BUF_BYTES (BUF_BYTES)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .max_payload   (max_payload_ff),
      .head          (head),
      .head_valid    (q_stat.head_valid),
      .pop           (pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_found     (rsp_tuser),
      .rsp_length    (length),
      .rsp_checksum  (checksum),
      .rsp_skipped   (skipped),
      .rsp_read_byte (read_byte),
      .stat          (e_stat)
   );

   // result word packing
   assign rsp_tdata = {6'd0, read_byte, skipped, checksum, length};

`ifndef SYNTH
   // read results carry only the byte
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[41:0] == 42'd0)
      else $error("read result with frame fields set");

   // frame results carry no byte
   a_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[49:42] == 8'd0)
      else $error("frame result with read byte set");

   // scan position never passes the fill level, fill within the store
   a_levels: assert property (@(posedge clock) disable iff (reset)
      e_stat.scan <= e_stat.fill && e_stat.fill <= mlfd_pkg::LEN_W'(BUF_BYTES))
      else $error("store levels out of order");

   // queue ready follows its occupancy
   a_queue: assert property (@(posedge clock) disable iff (reset)
      req_tready == (q_stat.count != 2'd2) && q_stat.count != 2'd3)
      else $error("queue occupancy wrong");
`endif

endmodule

// ===== verif/marker_length_frame_deframer_core_tb.sv =====
// self-checking testbench for the marker/length frame deframer core
module marker_length_frame_deframer_core_tb;

   localparam int STORE_BYTES = 1024;
   localparam int SETTLE_CYCLES = 3500;
   localparam longint CYCLE_LIMIT = 6000000;

   // one expected result word
   typedef struct {
      logic       found;
      logic [9:0] length;
      logic [15:0] checksum;
      logic [15:0] skipped;
      logic [7:0] rd_byte;
   } deframe_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic        req_tuser;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        rsp_tuser;
   logic [55:0] rsp_tdata;
   logic        csr_wr_en;
   logic [9:0]  csr_wr_data;

   // predictor state
   logic [7:0]  stored_bytes [0:STORE_BYTES-1];
   int          scan_pos;
   int          fill_pos;
   int          skip_total;
   bit          held_valid;
   int          held_start;
   int          held_length;
   int          payload_limit;

   deframe_result_type pending_results[$];
   int          error_count;
   longint      cycle_count;
   bit          idle_on;
   bit          hold_go;
   bit          hold_seen;
   int          hold_left;

   marker_length_frame_deframer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock generation
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[marker_length_frame_deframer_core] ERROR");
         $finish;
      end
   end

   // result side ready, with a counted long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_go != hold_seen) begin
         hold_seen = hold_go;
         hold_left = 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !idle_on || ($urandom_range(99) >= 36);
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      deframe_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.found)
               report_mismatch("frame_found", rsp_tuser, want.found);
            if (rsp_tdata[9:0] !== want.length)
               report_mismatch("frame_length", rsp_tdata[9:0], want.length);
            if (rsp_tdata[25:10] !== want.checksum)
               report_mismatch("frame_checksum", rsp_tdata[25:10], want.checksum);
            if (rsp_tdata[41:26] !== want.skipped)
               report_mismatch("skipped_count", rsp_tdata[41:26], want.skipped);
            if (rsp_tdata[49:42] !== want.rd_byte)
               report_mismatch("read_byte", rsp_tdata[49:42], want.rd_byte);
         end
      end
   end

   function automatic int be16(input int pos);
      return {stored_bytes[pos], stored_bytes[pos+1]};
   endfunction

   // deframer predictor, updated once per accepted word
   task automatic predict_word(input logic func, input logic [7:0] sbyte, input logic [9:0] idx);
      deframe_result_type res;
      int lim;
      int len;
      int csum;
      bit found;
      res = '{default: '0};
      lim = (payload_limit > STORE_BYTES - mlfd_pkg::FRAME_OVERHEAD) ?
            STORE_BYTES - mlfd_pkg::FRAME_OVERHEAD : payload_limit;
      if (func == mlfd_pkg::FUNC_READ) begin
         if (held_valid && idx < held_length)
            res.rd_byte = stored_bytes[held_start + 4 + idx];
         pending_results.push_back(res);
         return;
      end
      held_valid = 0;
      // full store: move unscanned bytes down
      if (fill_pos >= STORE_BYTES) begin
         for (int i = 0; i < fill_pos - scan_pos; i++)
            stored_bytes[i] = stored_bytes[scan_pos + i];
         fill_pos = fill_pos - scan_pos;
         scan_pos = 0;
         if (fill_pos >= STORE_BYTES)
            fill_pos = 0;
      end
      stored_bytes[fill_pos] = sbyte;
      fill_pos++;
      found = 0;
      len = 0;
      csum = 0;
      forever begin
         if (fill_pos - scan_pos < mlfd_pkg::FRAME_OVERHEAD) break;
         while (scan_pos + 1 < fill_pos &&
                !(stored_bytes[scan_pos] == mlfd_pkg::MARK_S0 &&
                  stored_bytes[scan_pos+1] == mlfd_pkg::MARK_S1)) begin
            if (skip_total < 65535) skip_total++;
            scan_pos++;
         end
         if (fill_pos - scan_pos < mlfd_pkg::FRAME_OVERHEAD) break;
         len = be16(scan_pos + 2);
         if (len > lim) begin
            scan_pos++;
            continue;
         end
         if (fill_pos - scan_pos < len + mlfd_pkg::FRAME_OVERHEAD) break;
         csum = be16(scan_pos + 4 + len);
         if (stored_bytes[scan_pos+6+len] != mlfd_pkg::MARK_E0 ||
             stored_bytes[scan_pos+7+len] != mlfd_pkg::MARK_E1) begin
            scan_pos++;
            continue;
         end
         found = 1;
         break;
      end
      if (!found) return;
      held_valid = 1;
      held_start = scan_pos;
      held_length = len;
      res.found = 1'b1;
      res.length = len[9:0];
      res.checksum = csum[15:0];
      res.skipped = skip_total[15:0];
      pending_results.push_back(res);
      skip_total = 0;
      scan_pos = scan_pos + len + mlfd_pkg::FRAME_OVERHEAD;
      if (scan_pos == fill_pos) begin
         scan_pos = 0;
         fill_pos = 0;
      end
   endtask

   // offer one word and wait for its acceptance
   task automatic send_word(input logic func, input logic [7:0] sbyte, input logic [9:0] idx);
      int gap;
      if (idle_on && $urandom_range(99) < 36) begin
         gap = $urandom_range(4, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {6'd0, idx, sbyte};
      do @(posedge clock); while (!req_tready);
      predict_word(func, sbyte, idx);
   endtask

   task automatic push_byte(input logic [7:0] b);
      send_word(mlfd_pkg::FUNC_PUSH, b, 10'($urandom));
   endtask

   task automatic read_payload(input int idx);
      send_word(mlfd_pkg::FUNC_READ, 8'($urandom), idx[9:0]);
   endtask

   // whole frame; bad_end spoils the end marker
   task automatic push_frame(input int len, input bit bad_end);
      push_byte(mlfd_pkg::MARK_S0);
      push_byte(mlfd_pkg::MARK_S1);
      push_byte(len[15:8]);
      push_byte(len[7:0]);
      for (int i = 0; i < len; i++) push_byte(8'($urandom));
      push_byte(8'($urandom));
      push_byte(8'($urandom));
      push_byte(bad_end ? 8'($urandom_range(255, 0)) ^ mlfd_pkg::MARK_E0 ^ 8'h01
                        : mlfd_pkg::MARK_E0);
      push_byte(mlfd_pkg::MARK_E1);
   endtask

   // sender pause until all results are in, then let the engine settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input int value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[9:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      payload_limit = value;
   endtask

   // reads with no frame held, simple frames, skip count, held span
   task automatic test_basic();
      read_payload(0);
      read_payload(1015);
      push_frame(3, 0);
      read_payload(0);
      read_payload(2);
      read_payload(3);
      push_byte(8'h55);
      push_byte(mlfd_pkg::MARK_S0);
      push_frame(0, 0);
      read_payload(0);
      push_byte(8'hFF);
      read_payload(0);
   endtask

   // too-long length and bad end marker, with a good frame inside the bad one
   task automatic test_reject();
      write_limit(4);
      push_frame(5, 0);
      push_frame(4, 0);
      push_byte(mlfd_pkg::MARK_S0); push_byte(mlfd_pkg::MARK_S1);
      push_byte(8'h00); push_byte(8'h0A);
      push_byte(mlfd_pkg::MARK_S0); push_byte(mlfd_pkg::MARK_S1);
      push_byte(8'h00); push_byte(8'h02);
      push_byte(8'h11); push_byte(8'h22); push_byte(8'h33); push_byte(8'h44);
      push_byte(mlfd_pkg::MARK_E0); push_byte(mlfd_pkg::MARK_E1);
      push_byte(8'h12); push_byte(8'h34);
      push_frame(2, 1);
      push_byte(8'h00);
      read_payload(1);
   endtask

   // limit extremes, largest frame and limit above the store range
   task automatic test_limits();
      write_limit(0);
      push_frame(0, 0);
      push_frame(1, 0);
      write_limit(1023);
      push_frame(1016, 0);
      read_payload(1015);
      read_payload(1016);
      push_frame(1017, 0);
      write_limit(1016);
      push_frame(1016, 0);
      read_payload(0);
   endtask

   // store full: junk forces compaction and emptying
   task automatic test_store_full();
      for (int i = 0; i < 1100; i++) push_byte(8'($urandom_range(8'h9F)));
      push_byte(mlfd_pkg::MARK_S0); push_byte(mlfd_pkg::MARK_S1);
      push_byte(8'h03); push_byte(8'hE0);
      for (int i = 0; i < 700; i++) push_byte(8'($urandom_range(8'h9F)));
      push_frame(6, 0);
      read_payload(5);
   endtask

   // skip counter saturation
   task automatic test_skip_saturation();
      idle_on = 0;
      for (int i = 0; i < 65600; i++) push_byte(8'h00);
      push_frame(1, 0);
      push_frame(1, 0);
      idle_on = 1;
   endtask

   // result side holds off while requests keep coming
   task automatic test_backpressure();
      wait_idle();
      hold_go = !hold_go;
      push_frame(2, 0);
      for (int i = 0; i < 30; i++) read_payload($urandom_range(3));
      push_frame(1, 0);
   endtask

   // mostly well-formed frames with random content, some broken, some noise
   task automatic test_random(input int items);
      int sent;
      int kind;
      int len;
      sent = 0;
      while (sent < items) begin
         if (sent == items / 3) write_limit($urandom_range(1016, 20));
         if (sent == 2 * items / 3) write_limit($urandom_range(12, 0));
         idle_on = (sent >= 100);
         kind = $urandom_range(99);
         len = $urandom_range(12);
         if (kind < 60) begin
            push_frame(len, 0);
            sent += len + 8;
            repeat ($urandom_range(4)) begin
               read_payload($urandom_range(len + 2));
               sent++;
            end
         end else if (kind < 70) begin
            push_frame(len, 1);
            sent += len + 8;
         end else if (kind < 78) begin
            push_byte(mlfd_pkg::MARK_S0); push_byte(mlfd_pkg::MARK_S1);
            push_byte(8'($urandom)); push_byte(8'($urandom));
            sent += 4;
         end else if (kind < 90) begin
            repeat ($urandom_range(5, 1)) begin
               push_byte(8'($urandom));
               sent++;
            end
         end else begin
            read_payload($urandom_range(1015));
            sent++;
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = 1'b0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      error_count = 0;
      cycle_count = 0;
      idle_on     = 1;
      hold_go     = 0;
      hold_seen   = 0;
      hold_left   = 0;
      scan_pos    = 0;
      fill_pos    = 0;
      skip_total  = 0;
      held_valid  = 0;
      held_start  = 0;
      held_length = 0;
      payload_limit = mlfd_pkg::MAX_PAYLOAD_RST;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic();
      test_reject();
      test_limits();
      test_store_full();
      test_skip_saturation();
      test_backpressure();
      wait_idle();
      test_random(500);
      write_limit(mlfd_pkg::MAX_PAYLOAD_RST);
      test_random(60);

      wait_idle();
      if (error_count == 0) begin
         $display("[marker_length_frame_deframer_core] OK");
      end else begin
         $display("[marker_length_frame_deframer_core] ERROR");
      end
      $finish;
   end

endmodule
